>>> rtl/pcgbr_pkg.sv
`timescale 1ns / 1ps
// Package for the PCG32 bounded random generator: command codes, controller
// and datapath types, LCG constants and the seeded reset state.
// No dependencies.
package pcgbr_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned StateW = 64;

	localparam logic [StateW-1:0] PcgMult = 64'h5851f42d4c957f2d;
	localparam logic [WordW-1:0] SeedReset = 32'd1955588763;

	typedef enum logic [1:0] {
		CMD_RESEED = 2'd0,
		CMD_RAW    = 2'd1,
		CMD_UBOUND = 2'd2,
		CMD_SBOUND = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_RS_INIT,
		DP_STEP0,
		DP_STEP1,
		DP_STEP2,
		DP_STEP3,
		DP_RS_ADD
	} dp_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_RND,
		RES_LOW,
		RES_SUM
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP0,
		ST_STEP1,
		ST_STEP2,
		ST_STEP3,
		ST_RS_ADD,
		ST_THR_START,
		ST_THR_WAIT,
		ST_CHECK,
		ST_REM_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		dp_op_t   op;
		logic     div_start;
		logic     div_sel_rnd;
		logic     thr_load;
		logic     out_load;
		res_sel_t res_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic rnd_lt_thr;
		logic div_done;
	} dp_status_t;

	function automatic logic [StateW-1:0] pcg_lcg(logic [StateW-1:0] s, logic [WordW-1:0] inc);
		return s * PcgMult + {{(StateW-WordW){1'b0}}, inc};
	endfunction

	function automatic logic [StateW-1:0] pcg_seeded_state(logic [WordW-1:0] seed);
		logic [WordW-1:0]  inc;
		logic [StateW-1:0] s;
		inc = {seed[WordW-2:0], 1'b1};
		s = pcg_lcg('0, inc);
		s = s + {{(StateW-WordW){1'b0}}, seed};
		s = pcg_lcg(s, inc);
		return s;
	endfunction

	localparam logic [StateW-1:0] ResetState = pcg_seeded_state(SeedReset);
	localparam logic [WordW-1:0] ResetInc = {SeedReset[WordW-2:0], 1'b1};

endpackage

>>> rtl/pcgbr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response beats.
// No dependencies.
interface pcgbr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] low_bound;
	logic [31:0] high_bound;

	modport source (output valid, output cmd, output low_bound, output high_bound, input ready);
	modport sink (input valid, input cmd, input low_bound, input high_bound, output ready);
endinterface

interface pcgbr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

>>> rtl/pcgbr_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, remainder only, one quotient bit per cycle.
// Depends on pcgbr_pkg.
module pcgbr_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [pcgbr_pkg::WordW-1:0] dividend,
	input  logic [pcgbr_pkg::WordW-1:0] divisor,
	output logic                     done,
	output logic [pcgbr_pkg::WordW-1:0] rem
);
	import pcgbr_pkg::*;

	localparam int unsigned CntW = $clog2(WordW);
	localparam logic [CntW-1:0] CntLast = CntW'(WordW - 1);

	logic            run_q;
	logic            done_q;
	logic [CntW-1:0] cnt_q;
	logic [WordW-1:0] rem_q;
	logic [WordW-1:0] sh_q;
	logic [WordW:0]  trial;
	logic [WordW:0]  diff;
	logic            ge;
	logic [WordW-1:0] rem_nxt;

	assign trial   = {rem_q, sh_q[WordW-1]};
	assign ge      = trial >= {1'b0, divisor};
	assign diff    = trial - {1'b0, divisor};
	assign rem_nxt = ge ? diff[WordW-1:0] : trial[WordW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntLast) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			sh_q  <= {sh_q[WordW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/pcgbr_dp.sv
`timescale 1ns / 1ps
// Datapath: LCG state, shared 32x32 multiplier, XSH-RR output, threshold,
// divider and output register. Depends on pcgbr_pkg and pcgbr_div.
module pcgbr_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     seed_wr_en,
	input  logic [pcgbr_pkg::WordW-1:0] seed_wr_data,
	input  logic [1:0]               req_cmd,
	input  logic [pcgbr_pkg::WordW-1:0] req_low,
	input  logic [pcgbr_pkg::WordW-1:0] req_high,
	input  pcgbr_pkg::ctrl_cmd_t     ctl,
	output pcgbr_pkg::dp_status_t    sts,
	output logic [pcgbr_pkg::WordW-1:0] value
);
	import pcgbr_pkg::*;

	logic [StateW-1:0] state_q;
	logic [WordW-1:0]  inc_q;
	logic [WordW-1:0]  seed_q;
	logic [WordW-1:0]  lo_q;
	logic [WordW-1:0]  range_q;
	logic [WordW-1:0]  thr_q;
	logic [WordW-1:0]  rnd_q;
	logic [StateW-1:0] mul_q;
	logic [StateW-1:0] acc_q;
	logic [WordW-1:0]  value_q;

	logic [WordW-1:0]  mul_a;
	logic [WordW-1:0]  mul_b;
	logic [StateW-1:0] mul_p;
	logic [StateW-1:0] xs_t;
	logic [WordW-1:0]  xs;
	logic [4:0]        rot;
	logic [StateW-1:0] rot_t;
	logic [WordW-1:0]  rnd_nxt;
	logic [WordW-1:0]  div_dividend;
	logic              div_done;
	logic [WordW-1:0]  div_rem;
	logic [WordW-1:0]  res;

	// XSH-RR on the old state
	assign xs_t    = state_q ^ (state_q >> 18);
	assign xs      = xs_t[58:27];
	assign rot     = state_q[63:59];
	assign rot_t   = {xs, xs} >> rot;
	assign rnd_nxt = rot_t[WordW-1:0];

	always_comb begin
		mul_a = state_q[WordW-1:0];
		mul_b = PcgMult[WordW-1:0];
		case (ctl.op)
			DP_STEP1: begin
				mul_a = state_q[StateW-1:WordW];
			end
			DP_STEP2: begin
				mul_b = PcgMult[StateW-1:WordW];
			end
			default: begin
			end
		endcase
	end

	assign mul_p = {{WordW{1'b0}}, mul_a} * {{WordW{1'b0}}, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ResetState;
			inc_q   <= ResetInc;
			seed_q  <= SeedReset;
		end else begin
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
			end
			unique case (ctl.op)
				DP_RS_INIT: begin
					state_q <= '0;
					inc_q   <= {seed_q[WordW-2:0], 1'b1};
				end
				DP_STEP3: begin
					state_q <= {acc_q[StateW-1:WordW] + mul_q[WordW-1:0], acc_q[WordW-1:0]};
				end
				DP_RS_ADD: begin
					state_q <= state_q + {{(StateW-WordW){1'b0}}, seed_q};
				end
				DP_NOP, DP_LOAD, DP_STEP0, DP_STEP1, DP_STEP2: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			DP_LOAD: begin
				lo_q    <= req_low;
				range_q <= req_high - req_low;
			end
			DP_STEP0: begin
				mul_q <= mul_p;
				rnd_q <= rnd_nxt;
			end
			DP_STEP1: begin
				mul_q <= mul_p;
				acc_q <= mul_q + {{(StateW-WordW){1'b0}}, inc_q};
			end
			DP_STEP2: begin
				mul_q <= mul_p;
				acc_q[StateW-1:WordW] <= acc_q[StateW-1:WordW] + mul_q[WordW-1:0];
			end
			DP_NOP, DP_RS_INIT, DP_STEP3, DP_RS_ADD: begin
			end
		endcase
		if (ctl.thr_load) begin
			thr_q <= div_rem;
		end
		if (ctl.out_load) begin
			value_q <= res;
		end
	end

	assign div_dividend = ctl.div_sel_rnd ? rnd_q : (WordW'(0) - range_q);

	pcgbr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_dividend),
		.divisor  (range_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		unique case (ctl.res_sel)
			RES_ZERO: res = '0;
			RES_RND:  res = rnd_q;
			RES_LOW:  res = lo_q;
			RES_SUM:  res = lo_q + div_rem;
		endcase
	end

	assign sts.empty      = (req_cmd == CMD_SBOUND) ? ($signed(req_low) >= $signed(req_high))
	                                                : (req_low >= req_high);
	assign sts.rnd_lt_thr = rnd_q < thr_q;
	assign sts.div_done   = div_done;
	assign value          = value_q;

endmodule

>>> rtl/pcgbr_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences reseed, LCG steps, divides and rejection retries,
// and owns the handshakes. Depends on pcgbr_pkg.
module pcgbr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic [1:0]            req_cmd,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  pcgbr_pkg::dp_status_t sts,
	output pcgbr_pkg::ctrl_cmd_t  ctl
);
	import pcgbr_pkg::*;

	state_t   state_q;
	state_t   state_nxt;
	cmd_t     cmd_q;
	cmd_t     cmd_in;
	logic     pass_q;
	res_sel_t res_sel_q;
	logic     out_valid_q;
	logic     accept;
	logic     out_free;

	assign cmd_in   = cmd_t'(req_cmd);
	assign accept   = req_valid && req_ready;
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_in) inside
						CMD_RESEED, CMD_RAW: state_nxt = ST_STEP0;
						CMD_UBOUND, CMD_SBOUND: state_nxt = sts.empty ? ST_FINISH : ST_THR_START;
					endcase
				end
			end
			ST_STEP0: state_nxt = ST_STEP1;
			ST_STEP1: state_nxt = ST_STEP2;
			ST_STEP2: state_nxt = ST_STEP3;
			ST_STEP3: begin
				unique case (cmd_q) inside
					CMD_RESEED: state_nxt = pass_q ? ST_FINISH : ST_RS_ADD;
					CMD_RAW: state_nxt = ST_FINISH;
					CMD_UBOUND, CMD_SBOUND: state_nxt = ST_CHECK;
				endcase
			end
			ST_RS_ADD: state_nxt = ST_STEP0;
			ST_THR_START: state_nxt = ST_THR_WAIT;
			ST_THR_WAIT: begin
				if (sts.div_done) begin
					state_nxt = ST_STEP0;
				end
			end
			ST_CHECK: state_nxt = sts.rnd_lt_thr ? ST_STEP0 : ST_REM_WAIT;
			ST_REM_WAIT: begin
				if (sts.div_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op          = DP_NOP;
		ctl.div_start   = 1'b0;
		ctl.div_sel_rnd = 1'b0;
		ctl.thr_load    = 1'b0;
		ctl.out_load    = 1'b0;
		ctl.res_sel     = res_sel_q;
		req_ready       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (accept) begin
					ctl.op = (cmd_in == CMD_RESEED) ? DP_RS_INIT : DP_LOAD;
				end
			end
			ST_STEP0: ctl.op = DP_STEP0;
			ST_STEP1: ctl.op = DP_STEP1;
			ST_STEP2: ctl.op = DP_STEP2;
			ST_STEP3: ctl.op = DP_STEP3;
			ST_RS_ADD: ctl.op = DP_RS_ADD;
			ST_THR_START: ctl.div_start = 1'b1;
			ST_THR_WAIT: ctl.thr_load = sts.div_done;
			ST_CHECK: begin
				ctl.div_start   = !sts.rnd_lt_thr;
				ctl.div_sel_rnd = 1'b1;
			end
			ST_REM_WAIT: begin
			end
			ST_FINISH: ctl.out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_RAW;
			pass_q      <= 1'b0;
			res_sel_q   <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cmd_q  <= cmd_in;
				pass_q <= 1'b0;
				unique case (cmd_in) inside
					CMD_RESEED: res_sel_q <= RES_ZERO;
					CMD_RAW: res_sel_q <= RES_RND;
					CMD_UBOUND, CMD_SBOUND: res_sel_q <= sts.empty ? RES_LOW : RES_SUM;
				endcase
			end
			if (state_q == ST_RS_ADD) begin
				pass_q <= 1'b1;
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

	a_finish_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> out_valid_q)
		else $error("finished beat not placed in output register");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted beat left controller idle");

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_THR_WAIT || state_q == ST_REM_WAIT))
		else $error("divider finished outside a wait state");

	a_step_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP0) |=> (state_q == ST_STEP1) ##1 (state_q == ST_STEP2)
		##1 (state_q == ST_STEP3))
		else $error("LCG step sequence broken");

	a_reseed_add_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RS_ADD) |-> (cmd_q == CMD_RESEED && !pass_q))
		else $error("seed add outside first reseed pass");

endmodule

>>> rtl/pcg32_bounded_random.sv
`timescale 1ns / 1ps
// Top level of the PCG32 bounded random generator.
// Depends on pcgbr_pkg, pcgbr_if, pcgbr_ctrl, pcgbr_dp.
//
// PCG32 (XSH-RR, 64-bit LCG) generator handling one request beat at a time.
// Each LCG step runs through the states STEP0 to STEP3 on one shared 32x32
// multiplier. A bounded draw with low below high runs two bit-serial
// remainder operations (threshold and final modulo) and one LCG step, and
// each rejected word costs another LCG step. A bounded request with an empty
// interval returns low without advancing the generator. The generator state
// is preloaded at reset with the state seeded by the reset seed, so requests
// are taken right after reset. A new request is accepted while the previous
// response beat still waits in the output register.
module pcg32_bounded_random (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     seed_wr_en,
	input  logic [pcgbr_pkg::WordW-1:0] seed_wr_data,
	pcgbr_req_if.sink                req,
	pcgbr_rsp_if.source              rsp
);
	import pcgbr_pkg::*;

	ctrl_cmd_t  ctl;
	dp_status_t sts;

	pcgbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	pcgbr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_wr_en   (seed_wr_en),
		.seed_wr_data (seed_wr_data),
		.req_cmd      (req.cmd),
		.req_low      (req.low_bound),
		.req_high     (req.high_bound),
		.ctl          (ctl),
		.sts          (sts),
		.value        (rsp.value)
	);

endmodule
